/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/prewma_pkg.sv */
// ---------------------------------------------------------------------------
// prewma_pkg
// Types and constants of the peer RSSI average table.
// ---------------------------------------------------------------------------
`default_nettype none

package prewma_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW  = $clog2(TableEntries + 1);

  localparam int unsigned MacW   = 48;
  localparam int unsigned AvgW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RssiW  = 8;
  localparam int unsigned AlphaW = 9;
  localparam int unsigned ExpW   = 5;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ProdW  = 26;

  localparam logic [AlphaW-1:0] AlphaOne     = 9'd256;
  localparam logic [AlphaW-1:0] AlphaReset   = 9'd77;
  localparam logic [TimeW-1:0]  TimeoutReset = 32'd30000;

  typedef enum logic [1:0] {
    ModeFrame = 2'd0,
    ModeQuery = 2'd1,
    ModeSweep = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    RegAlpha   = 1'b0,
    RegTimeout = 1'b1
  } reg_e;

  typedef struct packed {
    logic [MacW-1:0]        mac;
    logic signed [AvgW-1:0] avg;
    logic [TimeW-1:0]       last_seen;
  } entry_t;

endpackage

`default_nettype wire

/* sv/peer_rssi_ewma_table_core.sv */
// ---------------------------------------------------------------------------
// peer_rssi_ewma_table_core
// Per-peer RSSI table keyed by MAC: EWMA update on frames, queries, and
// inactivity sweeps. Rows live in one synchronous memory, scanned per item.
// ---------------------------------------------------------------------------
// Channel   Handshake              Payload
// command   start / busy           mode_i, peer_mac_i, sample_rssi_i, now_ms_i
// result    done_o (1-cycle)       found_o, slot_o, average_q8_o,
//                                  expired_count_o, latest_rssi_o
// config    APB psel/penable/...   paddr, pwdata, prdata (0: alpha, 4: timeout)
//
// Every item keeps busy high through its steps: one memory read per row over
// the single read port, a wait for the registered read of the last row, the
// blend multiply, and write-back.
// done_o follows in the next cycle, where busy is already low and a new item
// may be accepted; a new item is never taken while one is in progress.
// Reset clears the row valid flags at once; no clearing pass is needed.
// The receiver cannot stall; results are shown for one cycle only.
// ---------------------------------------------------------------------------
`default_nettype none

module peer_rssi_ewma_table_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            mode_i,
  input  wire logic [prewma_pkg::MacW-1:0]           peer_mac_i,
  input  wire logic signed [prewma_pkg::RssiW-1:0]   sample_rssi_i,
  input  wire logic [prewma_pkg::TimeW-1:0]          now_ms_i,
  output logic                                       done_o,
  output logic                                       found_o,
  output logic [prewma_pkg::SlotW-1:0]               slot_o,
  output logic signed [prewma_pkg::AvgW-1:0]        average_q8_o,
  output logic [prewma_pkg::ExpW-1:0]                expired_count_o,
  output logic signed [prewma_pkg::RssiW-1:0]        latest_rssi_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [prewma_pkg::AddrW-1:0]          paddr,
  input  wire logic [prewma_pkg::DataW-1:0]          pwdata,
  output logic [prewma_pkg::DataW-1:0]               prdata,
  output logic                                       pready
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StMul   = 4'b0100,
    StWrite = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Command latched at accept
  prewma_pkg::mode_e                     mode_q;
  logic [prewma_pkg::MacW-1:0]           mac_q;
  logic signed [prewma_pkg::RssiW-1:0]   rssi_q;
  logic [prewma_pkg::TimeW-1:0]          now_q;
  logic signed [prewma_pkg::RssiW-1:0]   last_rssi_q;

  // Configuration
  logic [prewma_pkg::AlphaW-1:0]         alpha_q;
  logic [prewma_pkg::TimeW-1:0]          timeout_q;

  // Row storage
  logic [prewma_pkg::TableEntries-1:0]   valid_q;
  prewma_pkg::entry_t                    mem_q [prewma_pkg::TableEntries];
  prewma_pkg::entry_t                    rd_data_q;
  prewma_pkg::entry_t                    wr_entry;
  logic                                  mem_we;
  logic                                  rd_en;
  logic [prewma_pkg::IdxW-1:0]           rd_addr;

  // Scan bookkeeping
  logic [prewma_pkg::CntW-1:0]           rd_cnt_q;
  logic                                  proc_vld_q;
  logic [prewma_pkg::IdxW-1:0]           proc_idx_q;
  logic                                  hit_q;
  logic [prewma_pkg::IdxW-1:0]           hit_idx_q;
  logic signed [prewma_pkg::AvgW-1:0]    hit_avg_q;
  logic                                  free_q;
  logic [prewma_pkg::IdxW-1:0]           free_idx_q;
  logic                                  old_have_q;
  logic [prewma_pkg::IdxW-1:0]           old_idx_q;
  logic [prewma_pkg::TimeW-1:0]          old_ts_q;
  logic [prewma_pkg::ExpW-1:0]           exp_cnt_q;

  // Blend products
  logic signed [prewma_pkg::ProdW-1:0]   p1_q;
  logic signed [prewma_pkg::ProdW-1:0]   p2_q;

  // Result registers
  logic                                  done_q;
  logic                                  found_q;
  logic [prewma_pkg::SlotW-1:0]          slot_q;
  logic signed [prewma_pkg::AvgW-1:0]    avg_q;
  logic [prewma_pkg::ExpW-1:0]           exp_q;

  logic                                  accept;
  logic                                  cfg_we;
  logic                                  ent_valid;
  logic                                  ent_hit;
  logic                                  ent_free;
  logic                                  ent_older;
  logic                                  ent_expire;
  logic                                  last_proc;
  logic [prewma_pkg::TimeW-1:0]          idle_ms;
  logic [prewma_pkg::AlphaW-1:0]         a_sat;
  logic signed [prewma_pkg::ProdW-1:0]   a_ext;
  logic signed [prewma_pkg::ProdW-1:0]   b_ext;
  logic signed [prewma_pkg::ProdW-1:0]   rssi_ext;
  logic signed [prewma_pkg::ProdW-1:0]   avg_ext;
  logic signed [prewma_pkg::ProdW-1:0]   blend;
  logic signed [prewma_pkg::AvgW-1:0]    new_avg;
  logic [prewma_pkg::IdxW-1:0]           target_idx;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  always_comb begin
    unique case (prewma_pkg::reg_e'(paddr[2]))
      prewma_pkg::RegAlpha:   prdata = {{(prewma_pkg::DataW - prewma_pkg::AlphaW){1'b0}},
                                        alpha_q};
      prewma_pkg::RegTimeout: prdata = timeout_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= prewma_pkg::AlphaReset;
      timeout_q <= prewma_pkg::TimeoutReset;
    end else if (cfg_we) begin
      unique case (prewma_pkg::reg_e'(paddr[2]))
        prewma_pkg::RegAlpha:   alpha_q   <= pwdata[prewma_pkg::AlphaW-1:0];
        prewma_pkg::RegTimeout: timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Row memory: one read port, one write port, registered read.
  // Write-back happens before busy drops, so the next scan never overlaps it.
  // -------------------------------------------------------------------------
  assign rd_en   = (state_q == StScan) && (rd_cnt_q < prewma_pkg::CntW'(prewma_pkg::TableEntries));
  assign rd_addr = rd_cnt_q[prewma_pkg::IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[target_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // -------------------------------------------------------------------------
  // Per-row evaluation of the entry returned by the memory
  // -------------------------------------------------------------------------
  assign ent_valid  = valid_q[proc_idx_q];
  assign idle_ms    = now_q - rd_data_q.last_seen;
  assign ent_hit    = proc_vld_q && ent_valid && (rd_data_q.mac == mac_q);
  assign ent_free   = proc_vld_q && !ent_valid;
  assign ent_older  = proc_vld_q && ent_valid &&
                      (!old_have_q || (rd_data_q.last_seen < old_ts_q));
  assign ent_expire = proc_vld_q && ent_valid && (mode_q == prewma_pkg::ModeSweep) &&
                      (idle_ms > timeout_q);
  assign last_proc  = proc_vld_q &&
                      (proc_idx_q == prewma_pkg::IdxW'(prewma_pkg::TableEntries - 1));

  // -------------------------------------------------------------------------
  // Blend: avg' = a*rssi + floor((256 - a)*avg / 256)
  // -------------------------------------------------------------------------
  assign a_sat    = (alpha_q > prewma_pkg::AlphaOne) ? prewma_pkg::AlphaOne : alpha_q;
  assign a_ext    = signed'({{(prewma_pkg::ProdW - prewma_pkg::AlphaW){1'b0}}, a_sat});
  assign b_ext    = signed'({{(prewma_pkg::ProdW - prewma_pkg::AlphaW){1'b0}},
                             prewma_pkg::AlphaOne - a_sat});
  assign rssi_ext = signed'({{(prewma_pkg::ProdW - prewma_pkg::RssiW){rssi_q[prewma_pkg::RssiW-1]}},
                             rssi_q});
  assign avg_ext  = signed'({{(prewma_pkg::ProdW - prewma_pkg::AvgW){hit_avg_q[prewma_pkg::AvgW-1]}},
                             hit_avg_q});
  assign blend    = p1_q + (p2_q >>> 8);
  assign new_avg  = hit_q ? blend[prewma_pkg::AvgW-1:0] : signed'({rssi_q, 8'h00});

  always_comb begin
    priority if (hit_q) begin
      target_idx = hit_idx_q;
    end else if (free_q) begin
      target_idx = free_idx_q;
    end else begin
      target_idx = old_idx_q;
    end
  end

  assign mem_we             = (state_q == StWrite) && (mode_q == prewma_pkg::ModeFrame);
  assign wr_entry.mac       = mac_q;
  assign wr_entry.avg       = new_avg;
  assign wr_entry.last_seen = now_q;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StScan;
      StScan:  if (last_proc) state_d = StMul;
      StMul:   state_d = StWrite;
      StWrite: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_rssi_q <= '0;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      proc_vld_q  <= 1'b0;
      proc_idx_q  <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      old_have_q  <= 1'b0;
      exp_cnt_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= (state_q == StWrite);
      proc_vld_q <= rd_en;
      if (rd_en) begin
        proc_idx_q <= rd_addr;
        rd_cnt_q   <= rd_cnt_q + 1'b1;
      end

      if (accept) begin
        rd_cnt_q   <= '0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
        old_have_q <= 1'b0;
        exp_cnt_q  <= '0;
        if (prewma_pkg::mode_e'(mode_i) == prewma_pkg::ModeFrame) begin
          last_rssi_q <= sample_rssi_i;
        end
      end

      // First match wins; first empty row wins; strict compare keeps lowest index
      if (ent_hit && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (ent_free && !free_q) begin
        free_q <= 1'b1;
      end
      if (ent_older) begin
        old_have_q <= 1'b1;
      end
      if (ent_expire) begin
        valid_q[proc_idx_q] <= 1'b0;
        exp_cnt_q           <= exp_cnt_q + 1'b1;
      end

      if (mem_we) begin
        valid_q[target_idx] <= 1'b1;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= prewma_pkg::mode_e'(mode_i);
      mac_q  <= peer_mac_i;
      rssi_q <= sample_rssi_i;
      now_q  <= now_ms_i;
    end
    if (ent_hit && !hit_q) begin
      hit_idx_q <= proc_idx_q;
      hit_avg_q <= rd_data_q.avg;
    end
    if (ent_free && !free_q) begin
      free_idx_q <= proc_idx_q;
    end
    if (ent_older) begin
      old_idx_q <= proc_idx_q;
      old_ts_q  <= rd_data_q.last_seen;
    end
    if (state_q == StMul) begin
      p1_q <= a_ext * rssi_ext;
      p2_q <= b_ext * avg_ext;
    end
    if (state_q == StWrite) begin
      unique case (mode_q)
        prewma_pkg::ModeFrame: begin
          found_q <= hit_q;
          slot_q  <= prewma_pkg::SlotW'(target_idx);
          avg_q   <= new_avg;
          exp_q   <= '0;
        end
        prewma_pkg::ModeQuery: begin
          found_q <= hit_q;
          slot_q  <= hit_q ? prewma_pkg::SlotW'(hit_idx_q) : '0;
          avg_q   <= hit_q ? hit_avg_q : '0;
          exp_q   <= '0;
        end
        prewma_pkg::ModeSweep: begin
          found_q <= 1'b0;
          slot_q  <= '0;
          avg_q   <= '0;
          exp_q   <= exp_cnt_q;
        end
        default: begin
          found_q <= 1'b0;
          slot_q  <= '0;
          avg_q   <= '0;
          exp_q   <= '0;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign slot_o          = slot_q;
  assign average_q8_o    = avg_q;
  assign expired_count_o = exp_q;
  assign latest_rssi_o   = last_rssi_q;

endmodule

`default_nettype wire

/* sv/prewma_chk.sv */
// ---------------------------------------------------------------------------
// prewma_chk
// Port-level checks of the peer RSSI average table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prewma_chk (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  start,
  input wire logic                                  busy,
  input wire logic                                  done_o,
  input wire logic                                  found_o,
  input wire logic [prewma_pkg::SlotW-1:0]          slot_o,
  input wire logic signed [prewma_pkg::AvgW-1:0]   average_q8_o,
  input wire logic [prewma_pkg::ExpW-1:0]           expired_count_o,
  input wire logic                                  pready
);

  // A result is shown only once the item is finished
  `ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // An accepted item holds the block busy in the following cycle
  `ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy && !done_o)

  // Results are single-cycle strobes, never back to back
  `ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)

  // Only a sweep reports expired rows, and a sweep reports no row
  `ASSERT_IMP(a_sweep_clean, clk_i, rst_ni, done_o && (expired_count_o != '0),
              !found_o && (slot_o == '0) && (average_q8_o == '0))

  `ASSERT_IMP(a_pready_high, clk_i, rst_ni, 1'b1, pready)

endmodule

bind peer_rssi_ewma_table_core prewma_chk u_prewma_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .found_o         (found_o),
  .slot_o          (slot_o),
  .average_q8_o    (average_q8_o),
  .expired_count_o (expired_count_o),
  .pready          (pready)
);

`default_nettype wire
